/* rtl/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* rtl/ghrd_pkg.sv */
package ghrd_pkg;

    // Input word: one report byte or a recalibrate command.
    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    // Output word: one decoded report.
    typedef struct packed {
        logic [15:0]       buttons;
        logic signed [7:0] main_x;
        logic signed [7:0] main_y;
        logic signed [7:0] second_x;
        logic signed [7:0] second_y;
        logic              full_format;
    } out_word_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEAD_BAND   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FULL_SCALE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SWAP_STICKS = 2'd2;

    localparam logic [10:0] DEAD_BAND_RESET  = 11'd60;
    localparam logic [11:0] FULL_SCALE_RESET = 12'd1150;
    localparam logic [11:0] NEUTRAL_RESET    = 12'd2048;

    localparam int         HDR_LEN   = 12;
    localparam logic [3:0] COUNT_MAX = 4'd15;

    localparam logic [7:0] ID_FULL_STD    = 8'h30;
    localparam logic [7:0] ID_FULL_REPLY  = 8'h21;
    localparam logic [7:0] ID_FULL_EXT    = 8'h31;
    localparam logic [7:0] ID_SIMPLE      = 8'h3F;

    localparam logic [15:0] SIMPLE_BIAS = 16'h8000;
    localparam logic [14:0] SIMPLE_DIV  = 15'h7FFF;
    localparam logic [6:0]  AXIS_MAX    = 7'd127;

    // Restoring divider: one step for the saturation test, seven for the quotient.
    localparam int DIV_STEPS = 8;

    // Button bit positions.
    localparam int BTN_A     = 0;
    localparam int BTN_B     = 1;
    localparam int BTN_X     = 2;
    localparam int BTN_Y     = 3;
    localparam int BTN_L     = 4;
    localparam int BTN_R     = 5;
    localparam int BTN_ZL    = 6;
    localparam int BTN_ZR    = 7;
    localparam int BTN_MINUS = 8;
    localparam int BTN_PLUS  = 9;
    localparam int BTN_L3    = 10;
    localparam int BTN_R3    = 11;
    localparam int BTN_UP    = 12;
    localparam int BTN_DOWN  = 13;
    localparam int BTN_LEFT  = 14;
    localparam int BTN_RIGHT = 15;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_LOAD,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_STORE,
        ST_EMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       byte_take;
        logic       recal;
        logic       start;
        logic       load;
        logic       prep;
        logic       mul;
        logic       div_step;
        logic       store;
        logic       emit;
        logic [1:0] axis;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_full;
        logic is_simple;
        logic out_free;
    } dp_status_t;

    function automatic logic [15:0] full_buttons(input logic [7:0] rt, input logic [7:0] sh,
                                                 input logic [7:0] lf);
        logic [15:0] b;
        b            = '0;
        b[BTN_Y]     = rt[0];
        b[BTN_X]     = rt[1];
        b[BTN_B]     = rt[2];
        b[BTN_A]     = rt[3];
        b[BTN_R]     = rt[6];
        b[BTN_ZR]    = rt[7];
        b[BTN_MINUS] = sh[0];
        b[BTN_PLUS]  = sh[1];
        b[BTN_R3]    = sh[2];
        b[BTN_L3]    = sh[3];
        b[BTN_DOWN]  = lf[0];
        b[BTN_UP]    = lf[1];
        b[BTN_RIGHT] = lf[2];
        b[BTN_LEFT]  = lf[3];
        b[BTN_L]     = lf[6];
        b[BTN_ZL]    = lf[7];
        return b;
    endfunction

    function automatic logic [15:0] simple_buttons(input logic [7:0] lo, input logic [7:0] hi,
                                                   input logic [7:0] hat);
        logic [15:0] b;
        b            = '0;
        b[BTN_B]     = lo[0];
        b[BTN_A]     = lo[1];
        b[BTN_Y]     = lo[2];
        b[BTN_X]     = lo[3];
        b[BTN_L]     = lo[4];
        b[BTN_R]     = lo[5];
        b[BTN_ZL]    = lo[6];
        b[BTN_ZR]    = lo[7];
        b[BTN_MINUS] = hi[0];
        b[BTN_PLUS]  = hi[1];
        b[BTN_L3]    = hi[2];
        b[BTN_R3]    = hi[3];
        // Hat values of eight and above mean the pad is released.
        if (hat[7:3] == 5'd0)
        begin
            case (hat[2:0])
                3'd0:    b[BTN_UP] = 1'b1;
                3'd1:
                begin
                    b[BTN_UP]    = 1'b1;
                    b[BTN_RIGHT] = 1'b1;
                end
                3'd2:    b[BTN_RIGHT] = 1'b1;
                3'd3:
                begin
                    b[BTN_DOWN]  = 1'b1;
                    b[BTN_RIGHT] = 1'b1;
                end
                3'd4:    b[BTN_DOWN] = 1'b1;
                3'd5:
                begin
                    b[BTN_DOWN] = 1'b1;
                    b[BTN_LEFT] = 1'b1;
                end
                3'd6:    b[BTN_LEFT] = 1'b1;
                default:
                begin
                    b[BTN_UP]   = 1'b1;
                    b[BTN_LEFT] = 1'b1;
                end
            endcase
        end
        return b;
    endfunction

endpackage

/* rtl/ghrd_ctrl.sv */
// Sequencer: collects bytes, then walks the four axes through prepare,
// multiply, divide and store before handing the result to the output register.
module ghrd_ctrl import ghrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  in_word_t   in_word,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic [1:0]  axis_reg;
    logic [1:0]  axis_next;
    logic [2:0]  step_reg;
    logic [2:0]  step_next;

    logic take;
    logic decodable;

    assign take      = in_valid && (state_reg == ST_COLLECT) && !in_word.command;
    assign decodable = status.is_full || status.is_simple;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            axis_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            step_reg  <= step_next;
        end
    end

    // Next state and counters.
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (take && in_word.last_byte && decodable)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                axis_next  = '0;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'(DIV_STEPS - 1))
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                axis_next = axis_reg + 2'd1;
                if (axis_reg == 2'd3)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_PREP;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready      = (state_reg == ST_COLLECT);
        cmd.byte_take = take;
        cmd.recal     = in_valid && (state_reg == ST_COLLECT) && in_word.command;
        cmd.start     = take && in_word.last_byte && decodable;
        cmd.load      = (state_reg == ST_LOAD);
        cmd.prep      = (state_reg == ST_PREP);
        cmd.mul       = (state_reg == ST_MUL);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.store     = (state_reg == ST_STORE);
        cmd.emit      = (state_reg == ST_EMIT) && status.out_free;
        cmd.axis      = axis_reg;
    end

endmodule

/* rtl/ghrd_datapath.sv */
// Report buffer, stick neutrals, per-axis scaling with a shared restoring
// divider, and the output register.
module ghrd_datapath import ghrd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_word_t              out_word
);

    logic [10:0] dead_band_reg;
    logic [11:0] full_scale_reg;
    logic        swap_reg;

    logic [3:0]  byte_count_reg;
    logic [7:0]  header_reg [HDR_LEN];
    logic        origin_reg;
    logic [11:0] neutral_reg [4];
    logic        fmt_full_reg;
    logic [15:0] btn_reg;

    logic [15:0] mag_reg;
    logic [14:0] den_reg;
    logic        neg_reg;
    logic        zero_reg;
    logic        sat_reg;
    logic [21:0] rem_reg;
    logic [21:0] dsh_reg;
    logic [7:0]  q_reg;
    logic [7:0]  axis_res_reg [4];

    logic      out_valid_reg;
    out_word_t out_word_reg;

    logic [11:0] stick_raw [4];
    logic [11:0] stick_sw [4];
    logic [7:0]  report_id;
    logic        count_ok;

    logic [12:0] delta;
    logic [11:0] abs_delta;
    logic [12:0] excess;
    logic [12:0] span;
    logic [15:0] simple_raw;
    logic [15:0] simple_mag;
    logic [22:0] num_wide;
    logic [6:0]  mag7;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_band_reg  <= DEAD_BAND_RESET;
            full_scale_reg <= FULL_SCALE_RESET;
            swap_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEAD_BAND:   dead_band_reg  <= cfg_data[10:0];
                CFG_FULL_SCALE:  full_scale_reg <= cfg_data;
                CFG_SWAP_STICKS: swap_reg       <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Byte count saturates; only the first twelve bytes are kept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
        end
        else if (cmd.byte_take)
        begin
            if (last_byte)
            begin
                byte_count_reg <= '0;
            end
            else if (byte_count_reg != COUNT_MAX)
            begin
                byte_count_reg <= byte_count_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.byte_take && (byte_count_reg < 4'(HDR_LEN)))
        begin
            header_reg[byte_count_reg] <= data_byte;
        end
    end

    assign report_id = header_reg[0];
    // With eleven bytes already held, the last byte brings the count to twelve.
    assign count_ok  = (byte_count_reg >= 4'(HDR_LEN - 1));

    always_comb
    begin
        status.is_full   = count_ok && ((report_id == ID_FULL_STD) ||
                           (report_id == ID_FULL_REPLY) || (report_id == ID_FULL_EXT));
        status.is_simple = count_ok && (report_id == ID_SIMPLE);
        status.out_free  = !out_valid_reg || out_ready;
    end

    // Packed 12-bit stick fields of a full report, swapped on request.
    always_comb
    begin
        stick_raw[0] = {header_reg[7][3:0], header_reg[6]};
        stick_raw[1] = {header_reg[8], header_reg[7][7:4]};
        stick_raw[2] = {header_reg[10][3:0], header_reg[9]};
        stick_raw[3] = {header_reg[11], header_reg[10][7:4]};
        if (swap_reg)
        begin
            stick_sw[0] = stick_raw[2];
            stick_sw[1] = stick_raw[3];
            stick_sw[2] = stick_raw[0];
            stick_sw[3] = stick_raw[1];
        end
        else
        begin
            stick_sw = stick_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_full_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            fmt_full_reg <= status.is_full;
        end
    end

    // The first full report after reset or recalibration becomes the neutral.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                neutral_reg[i] <= NEUTRAL_RESET;
            end
        end
        else if (cmd.recal)
        begin
            origin_reg <= 1'b0;
        end
        else if (cmd.load && fmt_full_reg && !origin_reg)
        begin
            origin_reg <= 1'b1;
            for (int i = 0; i < 4; i++)
            begin
                neutral_reg[i] <= stick_sw[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (fmt_full_reg)
            begin
                btn_reg <= full_buttons(header_reg[3], header_reg[4], header_reg[5]);
            end
            else
            begin
                btn_reg <= simple_buttons(header_reg[1], header_reg[2], header_reg[3]);
            end
        end
    end

    // Axis preparation: magnitude, sign and divisor for the selected axis.
    always_comb
    begin
        delta     = {1'b0, stick_sw[cmd.axis]} - {1'b0, neutral_reg[cmd.axis]};
        abs_delta = delta[12] ? 12'(-delta) : delta[11:0];
        excess    = {1'b0, abs_delta} - {2'b0, dead_band_reg};
        span      = {1'b0, full_scale_reg} - {2'b0, dead_band_reg};
        case (cmd.axis)
            2'd0:    simple_raw = {header_reg[5], header_reg[4]};
            2'd1:    simple_raw = {header_reg[7], header_reg[6]};
            2'd2:    simple_raw = {header_reg[9], header_reg[8]};
            default: simple_raw = {header_reg[11], header_reg[10]};
        endcase
        simple_mag = simple_raw[15] ? {1'b0, simple_raw[14:0]} : (SIMPLE_BIAS - simple_raw);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            if (fmt_full_reg)
            begin
                mag_reg  <= {4'b0, excess[11:0]};
                den_reg  <= {3'b0, span[11:0]};
                neg_reg  <= delta[12];
                zero_reg <= excess[12] || (excess == 13'd0);
                sat_reg  <= span[12] || (span == 13'd0);
            end
            else
            begin
                mag_reg  <= simple_mag;
                den_reg  <= SIMPLE_DIV;
                neg_reg  <= !simple_raw[15];
                zero_reg <= 1'b0;
                sat_reg  <= 1'b0;
            end
        end
    end

    // Times 127 as a shift and subtract, then one quotient bit per cycle.
    assign num_wide = {mag_reg, 7'b0} - {7'b0, mag_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            rem_reg <= num_wide[21:0];
            dsh_reg <= {den_reg, 7'b0};
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[6:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[6:0], 1'b0};
            end
            dsh_reg <= {1'b0, dsh_reg[21:1]};
        end
    end

    // A set top quotient bit means the quotient reached 128 and saturates.
    assign mag7 = (sat_reg || q_reg[7]) ? AXIS_MAX : q_reg[6:0];

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            if (zero_reg)
            begin
                axis_res_reg[cmd.axis] <= '0;
            end
            else if (neg_reg)
            begin
                axis_res_reg[cmd.axis] <= 8'(-{1'b0, mag7});
            end
            else
            begin
                axis_res_reg[cmd.axis] <= {1'b0, mag7};
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_word_reg.buttons     <= btn_reg;
            out_word_reg.main_x      <= axis_res_reg[0];
            out_word_reg.main_y      <= axis_res_reg[1];
            out_word_reg.second_x    <= axis_res_reg[2];
            out_word_reg.second_y    <= axis_res_reg[3];
            out_word_reg.full_format <= fmt_full_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

/* rtl/gamepad_hid_report_decoder.sv */
// Gamepad HID input report decoder. Raw report bytes enter on the input channel
// one word per cycle, report id first, with last_byte set on the final byte; a
// word with command set is a recalibrate request that makes the next full report
// recapture the four stick neutrals. While bytes are being collected in_ready is
// high and a byte is taken every cycle, even while a decoded word waits in the
// output register. When the last byte of a report of twelve or more bytes with
// id 0x30, 0x21, 0x31 (full) or 0x3F (simple) is taken, the block decodes it and
// drops in_ready while it latches buttons and neutrals, then, for each of the four
// axes, prepares, multiplies by 127, runs eight steps of the shared restoring
// divider and stores, and finally loads the output register. The load waits if
// the previous output word has not yet been taken. Shorter reports and other ids
// produce no word. The configuration port writes dead_band (index 0), full_scale
// (index 1) and swap_sticks (index 2) with no read-back; it should only be
// written while the block is idle.
module gamepad_hid_report_decoder import ghrd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_word_t               in_word,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_word_t              out_word
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller sequences the decode; the datapath holds the report, configuration and result storage.
    ghrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_word  (in_word),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ghrd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .data_byte (in_word.data_byte),
        .last_byte (in_word.last_byte),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

/* rtl/ghrd_checker.sv */
`include "assert_macros.svh"

// Port-level checks for the report decoder.
module ghrd_checker import ghrd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_word
);

    logic axes_in_range;
    logic hat_consistent;

    assign axes_in_range  = (out_word.main_x != 8'sh80) && (out_word.main_y != 8'sh80) &&
                            (out_word.second_x != 8'sh80) && (out_word.second_y != 8'sh80);
    assign hat_consistent = !(out_word.buttons[BTN_UP] && out_word.buttons[BTN_DOWN]) &&
                            !(out_word.buttons[BTN_LEFT] && out_word.buttons[BTN_RIGHT]);

    // A stalled output word stays put.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word))

    // A decode always takes cycles with input held off, so no word follows an accept directly.
    `ASSERT_IMPLY(a_no_bypass, clk, rst_n, $rose(out_valid), !$past(in_valid && in_ready))

    // Scaled axes stay within -127..127.
    `ASSERT_IMPLY(a_axis_range, clk, rst_n, out_valid, axes_in_range)

    // The hat of a simple report never presses opposite directions.
    `ASSERT_IMPLY(a_hat_opposite, clk, rst_n, out_valid && !out_word.full_format, hat_consistent)

endmodule

bind gamepad_hid_report_decoder ghrd_checker u_ghrd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);

/* tb/gamepad_hid_report_decoder_tb.sv */
`timescale 1ns / 100ps

// Self-checking testbench for the gamepad HID report decoder.
//
// Report bytes are offered one word at a time on the input channel. Every accepted
// word is also run through a behavioral decoder kept in this file. That decoder has
// its own byte counter, header store, neutral capture and register copies, and it
// queues the decoded report that the block should produce. A checker process pops
// the oldest queued report whenever an output word is taken and compares every field.
//
// Both channel sides insert random idle cycles per word. A steady mode turns the
// idling off for stretches. One test holds the receiver off for a long time so that
// the single output register fills and the block stalls its input. Another pauses
// the sender until every queued report has come out.
module gamepad_hid_report_decoder_tb;
    import ghrd_pkg::*;

    // This many quiet cycles after the last expected word are enough for the block
    // to be idle again.
    localparam int SETTLE_CYCLES = 64;
    // Number of input words after which the random traffic stops.
    localparam int WORD_TARGET   = 1800;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_DEAD_BAND;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_word_t               in_word   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_word_t              out_word;

    always #1 clk = ~clk;

    gamepad_hid_report_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    // Behavioral copy of the block's state, starting from its reset values.
    logic [10:0] model_dead_band  = DEAD_BAND_RESET;
    logic [11:0] model_full_scale = FULL_SCALE_RESET;
    logic        model_swap       = 1'b0;
    logic [3:0]  model_count      = 4'd0;
    logic [7:0]  model_hdr [HDR_LEN];
    logic        model_origin     = 1'b0;
    logic [11:0] model_neutral [4] = '{NEUTRAL_RESET, NEUTRAL_RESET, NEUTRAL_RESET,
                                       NEUTRAL_RESET};

    // Decoded reports that are still to come out of the block, oldest first.
    out_word_t   expected_reports [$];
    out_word_t   head_report;

    // Bytes of the next report to send.
    logic [7:0]  report_buf [$];

    int          mismatch_count = 0;
    int          words_sent     = 0;
    int          recal_sent     = 0;
    int          full_seen      = 0;
    int          simple_seen    = 0;
    // When set, neither side idles.
    bit          steady         = 1'b0;
    // A nonzero value makes the receiver hold out_ready low for that many cycles.
    int          stall_request  = 0;

    // Dead band and linear scaling of one 12-bit stick axis around its neutral.
    function automatic int stick_deflection(input int raw, input int centre);
        int delta;
        int mag;
        int span;
        int v;
        delta = raw - centre;
        mag   = (delta < 0 ? -delta : delta) - int'(model_dead_band);
        span  = int'(model_full_scale) - int'(model_dead_band);
        if (mag <= 0)
            return 0;
        if (span <= 0)
            v = 127;
        else
        begin
            v = (mag * 127) / span;
            if (v > 127)
                v = 127;
        end
        return (delta < 0) ? -v : v;
    endfunction

    // Offset-binary 16-bit axis of a simple report scaled to -127..127.
    // Integer division truncates toward zero, as the block's arithmetic does.
    function automatic int pad_axis(input logic [7:0] lo, input logic [7:0] hi);
        int v;
        int a;
        v = int'({hi, lo}) - 32768;
        a = (v * 127) / 32767;
        if (a > 127)
            a = 127;
        if (a < -127)
            a = -127;
        return a;
    endfunction

    function automatic bit is_decoded_id(input logic [7:0] id);
        return id == ID_FULL_STD || id == ID_FULL_REPLY || id == ID_FULL_EXT ||
               id == ID_SIMPLE;
    endfunction

    // Advances the behavioral state by one accepted word and queues the decoded
    // report when the word completes a decodable report.
    task automatic predict_decode(input in_word_t w);
        int          n;
        int          ax [4];
        logic [11:0] raw [4];
        logic [11:0] t;
        logic [7:0]  id;
        out_word_t   r;
        // A recalibrate word only forgets the neutrals.
        if (w.command)
        begin
            model_origin = 1'b0;
            return;
        end
        if (model_count < HDR_LEN)
            model_hdr[model_count] = w.data_byte;
        if (model_count < COUNT_MAX)
            model_count = model_count + 4'd1;
        if (!w.last_byte)
            return;
        n           = model_count;
        model_count = 4'd0;
        if (n < HDR_LEN)
            return;
        id = model_hdr[0];
        r  = '0;
        if (id == ID_FULL_STD || id == ID_FULL_REPLY || id == ID_FULL_EXT)
        begin
            r.buttons[BTN_Y]     = model_hdr[3][0];
            r.buttons[BTN_X]     = model_hdr[3][1];
            r.buttons[BTN_B]     = model_hdr[3][2];
            r.buttons[BTN_A]     = model_hdr[3][3];
            r.buttons[BTN_R]     = model_hdr[3][6];
            r.buttons[BTN_ZR]    = model_hdr[3][7];
            r.buttons[BTN_MINUS] = model_hdr[4][0];
            r.buttons[BTN_PLUS]  = model_hdr[4][1];
            r.buttons[BTN_R3]    = model_hdr[4][2];
            r.buttons[BTN_L3]    = model_hdr[4][3];
            r.buttons[BTN_DOWN]  = model_hdr[5][0];
            r.buttons[BTN_UP]    = model_hdr[5][1];
            r.buttons[BTN_RIGHT] = model_hdr[5][2];
            r.buttons[BTN_LEFT]  = model_hdr[5][3];
            r.buttons[BTN_L]     = model_hdr[5][6];
            r.buttons[BTN_ZL]    = model_hdr[5][7];
            // Two 12-bit values are packed into each group of three bytes.
            raw[0] = {model_hdr[7][3:0], model_hdr[6]};
            raw[1] = {model_hdr[8], model_hdr[7][7:4]};
            raw[2] = {model_hdr[10][3:0], model_hdr[9]};
            raw[3] = {model_hdr[11], model_hdr[10][7:4]};
            if (model_swap)
            begin
                t      = raw[0];
                raw[0] = raw[2];
                raw[2] = t;
                t      = raw[1];
                raw[1] = raw[3];
                raw[3] = t;
            end
            // The first full report after reset or a recalibrate sets the neutrals
            // and is then scaled against them, so it reads as centered.
            if (!model_origin)
            begin
                model_origin = 1'b1;
                for (int i = 0; i < 4; i++)
                    model_neutral[i] = raw[i];
            end
            for (int i = 0; i < 4; i++)
                ax[i] = stick_deflection(int'(raw[i]), int'(model_neutral[i]));
            r.full_format = 1'b1;
        end
        else if (id == ID_SIMPLE)
        begin
            r.buttons[BTN_B]     = model_hdr[1][0];
            r.buttons[BTN_A]     = model_hdr[1][1];
            r.buttons[BTN_Y]     = model_hdr[1][2];
            r.buttons[BTN_X]     = model_hdr[1][3];
            r.buttons[BTN_L]     = model_hdr[1][4];
            r.buttons[BTN_R]     = model_hdr[1][5];
            r.buttons[BTN_ZL]    = model_hdr[1][6];
            r.buttons[BTN_ZR]    = model_hdr[1][7];
            r.buttons[BTN_MINUS] = model_hdr[2][0];
            r.buttons[BTN_PLUS]  = model_hdr[2][1];
            r.buttons[BTN_L3]    = model_hdr[2][2];
            r.buttons[BTN_R3]    = model_hdr[2][3];
            // The hat runs clockwise from up; eight and above is released.
            case (model_hdr[3])
                8'd0: r.buttons[BTN_UP] = 1'b1;
                8'd1:
                begin
                    r.buttons[BTN_UP]    = 1'b1;
                    r.buttons[BTN_RIGHT] = 1'b1;
                end
                8'd2: r.buttons[BTN_RIGHT] = 1'b1;
                8'd3:
                begin
                    r.buttons[BTN_DOWN]  = 1'b1;
                    r.buttons[BTN_RIGHT] = 1'b1;
                end
                8'd4: r.buttons[BTN_DOWN] = 1'b1;
                8'd5:
                begin
                    r.buttons[BTN_DOWN] = 1'b1;
                    r.buttons[BTN_LEFT] = 1'b1;
                end
                8'd6: r.buttons[BTN_LEFT] = 1'b1;
                8'd7:
                begin
                    r.buttons[BTN_UP]   = 1'b1;
                    r.buttons[BTN_LEFT] = 1'b1;
                end
                default: ;
            endcase
            for (int i = 0; i < 4; i++)
                ax[i] = pad_axis(model_hdr[4 + 2 * i], model_hdr[5 + 2 * i]);
            r.full_format = 1'b0;
        end
        else
            return;
        r.main_x   = 8'(ax[0]);
        r.main_y   = 8'(ax[1]);
        r.second_x = 8'(ax[2]);
        r.second_y = 8'(ax[3]);
        expected_reports.push_back(r);
    endtask

    // Offers one word after a random gap and returns at the edge that takes it.
    // Valid is only lowered when a gap is drawn, so it never drops and rises again
    // within one time step.
    task automatic send_word(input in_word_t w);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_decode(w);
        words_sent++;
        if (w.command)
            recal_sent++;
    endtask

    // A recalibrate word carries random, ignored data and last flag.
    task automatic send_recal();
        in_word_t w;
        w.command   = 1'b1;
        w.data_byte = 8'($urandom);
        w.last_byte = 1'($urandom);
        send_word(w);
    endtask

    // Sends report_buf, marking its final byte. A recalibrate word is slipped in
    // before byte recal_at when that index is within the report.
    task automatic send_bytes(input int recal_at);
        in_word_t w;
        for (int i = 0; i < report_buf.size(); i++)
        begin
            if (i == recal_at)
                send_recal();
            w.command   = 1'b0;
            w.data_byte = report_buf[i];
            w.last_byte = (i == report_buf.size() - 1);
            send_word(w);
        end
    endtask

    task automatic load_full(input logic [7:0] id, input logic [7:0] rt,
                             input logic [7:0] sh, input logic [7:0] lf,
                             input logic [11:0] x0, input logic [11:0] y0,
                             input logic [11:0] x1, input logic [11:0] y1);
        report_buf.delete();
        report_buf.push_back(id);
        report_buf.push_back(8'($urandom));
        report_buf.push_back(8'($urandom));
        report_buf.push_back(rt);
        report_buf.push_back(sh);
        report_buf.push_back(lf);
        report_buf.push_back(x0[7:0]);
        report_buf.push_back({y0[3:0], x0[11:8]});
        report_buf.push_back(y0[11:4]);
        report_buf.push_back(x1[7:0]);
        report_buf.push_back({y1[3:0], x1[11:8]});
        report_buf.push_back(y1[11:4]);
    endtask

    task automatic load_simple(input logic [7:0] lo, input logic [7:0] hi,
                               input logic [7:0] hat, input logic [15:0] a0,
                               input logic [15:0] a1, input logic [15:0] a2,
                               input logic [15:0] a3);
        report_buf.delete();
        report_buf.push_back(ID_SIMPLE);
        report_buf.push_back(lo);
        report_buf.push_back(hi);
        report_buf.push_back(hat);
        report_buf.push_back(a0[7:0]);
        report_buf.push_back(a0[15:8]);
        report_buf.push_back(a1[7:0]);
        report_buf.push_back(a1[15:8]);
        report_buf.push_back(a2[7:0]);
        report_buf.push_back(a2[15:8]);
        report_buf.push_back(a3[7:0]);
        report_buf.push_back(a3[15:8]);
    endtask

    // Half uniform, half clustered around mid-range so that the dead band and the
    // linear part of the scaling are reached as well as saturation.
    function automatic logic [11:0] pick_stick();
        int v;
        if ($urandom_range(0, 1) == 1)
            return 12'($urandom_range(0, 4095));
        v = 2048 + int'($urandom_range(0, 2600)) - 1300;
        return 12'(v);
    endfunction

    function automatic logic [15:0] pick_pad_axis();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return SIMPLE_BIAS;
            3:       return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_full_id();
        case ($urandom_range(0, 2))
            0:       return ID_FULL_STD;
            1:       return ID_FULL_REPLY;
            default: return ID_FULL_EXT;
        endcase
    endfunction

    // Builds and sends one random report. Most are well formed; the rest are
    // short, long, of an unknown id or interrupted by a recalibrate word.
    task automatic random_report();
        int         kind;
        int         shape;
        int         recal_at;
        logic [7:0] id;
        kind = $urandom_range(0, 99);
        if (kind < 55)
            load_full(pick_full_id(), 8'($urandom), 8'($urandom), 8'($urandom),
                      pick_stick(), pick_stick(), pick_stick(), pick_stick());
        else
            load_simple(8'($urandom), 8'($urandom),
                        ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 9))
                                                    : 8'($urandom),
                        pick_pad_axis(), pick_pad_axis(), pick_pad_axis(),
                        pick_pad_axis());
        if (kind >= 90)
        begin
            id = 8'($urandom);
            while (is_decoded_id(id))
                id = 8'($urandom);
            report_buf[0] = id;
        end
        shape = $urandom_range(0, 9);
        if (shape == 0)
        begin
            // Too short to decode.
            repeat (12 - $urandom_range(1, 11))
                void'(report_buf.pop_back());
        end
        else if (shape == 1)
            repeat ($urandom_range(4, 18))
                report_buf.push_back(8'($urandom));
        else if (shape == 2)
            repeat ($urandom_range(1, 3))
                report_buf.push_back(8'($urandom));
        if ($urandom_range(0, 24) == 0)
            send_recal();
        recal_at = -1;
        if ($urandom_range(0, 29) == 0)
            recal_at = $urandom_range(0, report_buf.size() - 1);
        send_bytes(recal_at);
    endtask

    // Drops valid and waits until every queued report has come out, then gives the
    // block time to finish any decode that is still running.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all three registers on consecutive cycles while the block is idle.
    task automatic set_config(input logic [10:0] db, input logic [11:0] fs,
                              input logic sw);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEAD_BAND;
        cfg_data  <= {1'b0, db};
        @(posedge clk);
        model_dead_band = db;
        cfg_index <= CFG_FULL_SCALE;
        cfg_data  <= fs;
        @(posedge clk);
        model_full_scale = fs;
        cfg_index <= CFG_SWAP_STICKS;
        cfg_data  <= {11'd0, sw};
        @(posedge clk);
        model_swap = sw;
        cfg_we <= 1'b0;
    endtask

    // Hand-picked reports with the reset register values: neutral capture, axis
    // extremes and dead band edges, every hat direction class, short, long and
    // unknown-id reports, a one-byte report and a recalibrate inside a report.
    task automatic test_directed();
        // Captures the neutrals at mid-range with every button byte set.
        load_full(ID_FULL_STD, 8'hFF, 8'hFF, 8'hFF, 12'd2048, 12'd2048, 12'd2048, 12'd2048);
        send_bytes(-1);
        // Axis extremes and both sides of the dead band edge.
        load_full(ID_FULL_REPLY, 8'h00, 8'h00, 8'h00, 12'd0, 12'd4095, 12'd2108, 12'd1987);
        send_bytes(-1);
        // Exactly full scale away from neutral, and single counts off neutral.
        load_full(ID_FULL_EXT, 8'h0F, 8'hF0, 8'hC3, 12'd3198, 12'd898, 12'd2049, 12'd2047);
        send_bytes(-1);
        // A recalibrate between reports makes the next full report the new neutral.
        send_recal();
        load_full(ID_FULL_STD, 8'hA5, 8'h5A, 8'h3C, 12'd500, 12'd3500, 12'd1000, 12'd3000);
        send_bytes(-1);
        load_full(ID_FULL_STD, 8'h96, 8'h69, 8'hC0, 12'd0, 12'd0, 12'd4095, 12'd4095);
        send_bytes(-1);
        // Simple report axis extremes and the bias point.
        load_simple(8'hFF, 8'hFF, 8'd0, 16'h0000, 16'hFFFF, SIMPLE_BIAS, 16'h7FFF);
        send_bytes(-1);
        load_simple(8'h00, 8'h00, 8'd7, 16'h8001, 16'h7FFE, 16'h0001, 16'hFFFE);
        send_bytes(-1);
        // Hat values of eight and above set no d-pad bits.
        load_simple(8'h55, 8'h0A, 8'd8, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom));
        send_bytes(-1);
        load_simple(8'hAA, 8'hF5, 8'd255, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom));
        send_bytes(-1);
        // Eleven bytes are one too few.
        load_full(ID_FULL_STD, 8'hFF, 8'hFF, 8'hFF, 12'd100, 12'd200, 12'd300, 12'd400);
        void'(report_buf.pop_back());
        send_bytes(-1);
        // Bytes beyond the twelfth are counted but not kept.
        load_full(ID_FULL_REPLY, 8'h11, 8'h22, 8'h44, 12'd3000, 12'd1000, 12'd2048, 12'd0);
        repeat (8)
            report_buf.push_back(8'($urandom));
        send_bytes(-1);
        // An id that is neither full nor simple.
        load_simple(8'hFF, 8'hFF, 8'd2, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        report_buf[0] = 8'h3E;
        send_bytes(-1);
        // A report that ends on its id byte.
        report_buf.delete();
        report_buf.push_back(ID_FULL_STD);
        send_bytes(-1);
        // A recalibrate word inside a report leaves the collected bytes alone.
        load_full(ID_FULL_EXT, 8'h3C, 8'h0C, 8'h0F, 12'd1800, 12'd2300, 12'd2100, 12'd2000);
        send_bytes(5);
        load_full(ID_FULL_STD, 8'h00, 8'h03, 8'h00, 12'd0, 12'd4095, 12'd4095, 12'd0);
        send_bytes(-1);
        drain_results();
    endtask

    // Register settings at and beyond the edges of their ranges, including a full
    // scale below the dead band and stick swapping.
    task automatic run_setting(input logic [10:0] db, input logic [11:0] fs,
                               input logic sw);
        set_config(db, fs, sw);
        send_recal();
        repeat (8)
            random_report();
    endtask

    task automatic test_register_extremes();
        run_setting(11'd0, 12'd1, 1'b0);
        run_setting(11'd2047, 12'd4095, 1'b1);
        run_setting(11'd500, 12'd200, 1'b0);
        run_setting(11'd300, 12'd300, 1'b1);
        run_setting(11'd0, 12'd4095, 1'b1);
        run_setting(11'd20, 12'd700, 1'b0);
        run_setting(DEAD_BAND_RESET, FULL_SCALE_RESET, 1'b0);
        drain_results();
    endtask

    // The receiver holds off long enough for a decoded word to sit in the output
    // register while the next decode finishes, so the input side must stall.
    task automatic test_output_stall();
        stall_request = 400;
        repeat (5)
        begin
            load_full(pick_full_id(), 8'($urandom), 8'($urandom), 8'($urandom),
                      pick_stick(), pick_stick(), pick_stick(), pick_stick());
            send_bytes(-1);
        end
        load_simple(8'($urandom), 8'($urandom), 8'($urandom_range(0, 9)),
                    pick_pad_axis(), pick_pad_axis(), pick_pad_axis(), pick_pad_axis());
        send_bytes(-1);
        drain_results();
    endtask

    // The sender stops mid-stream until every queued report has come out, then
    // carries on without touching the registers.
    task automatic test_paused_sender();
        repeat (6)
            random_report();
        drain_results();
        repeat (6)
            random_report();
    endtask

    // Bulk random traffic with occasional register changes and stretches in which
    // neither side idles.
    task automatic test_random_traffic();
        logic [10:0] db;
        logic [11:0] fs;
        while (words_sent < WORD_TARGET)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                db = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
                                                 : 11'($urandom_range(0, 200));
                fs = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(1, 4095))
                                                 : 12'($urandom_range(300, 2000));
                set_config(db, fs, 1'($urandom));
            end
            if ($urandom_range(0, 9) == 0)
                steady = ~steady;
            random_report();
        end
        steady = 1'b0;
    endtask

    // Receiver: a random number of idle cycles before each word, or a long hold-off
    // when a test asks for one.
    initial
    begin : receiver
        int gap;
        forever
        begin
            if (stall_request > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall_request) @(posedge clk);
                stall_request = 0;
            end
            gap = steady ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid && stall_request == 0)
                @(posedge clk);
        end
    end

    // Checker: every taken output word is matched against the oldest queued report.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: output word %h with no decoded report pending",
                             $realtime, out_word);
            end
            else
            begin
                head_report = expected_reports.pop_front();
                if (head_report.full_format)
                    full_seen++;
                else
                    simple_seen++;
                if (out_word.buttons     !== head_report.buttons  ||
                    out_word.main_x      !== head_report.main_x   ||
                    out_word.main_y      !== head_report.main_y   ||
                    out_word.second_x    !== head_report.second_x ||
                    out_word.second_y    !== head_report.second_y ||
                    out_word.full_format !== head_report.full_format)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: mismatch, expected btn %h x %0d y %0d x2 %0d y2 %0d full %b",
                                 $realtime, head_report.buttons, head_report.main_x,
                                 head_report.main_y, head_report.second_x,
                                 head_report.second_y, head_report.full_format);
                        $display("    got btn %h x %0d y %0d x2 %0d y2 %0d full %b",
                                 out_word.buttons, out_word.main_x, out_word.main_y,
                                 out_word.second_x, out_word.second_y,
                                 out_word.full_format);
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_extremes();
        test_output_stall();
        test_paused_sender();
        test_random_traffic();
        drain_results();
        $display("Sent %0d input words (%0d recalibrate) over several register settings.",
                 words_sent, recal_sent);
        $display("Checked %0d full and %0d simple decoded reports, %0d mismatches.",
                 full_seen, simple_seen, mismatch_count);
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("gamepad_hid_report_decoder test passed");
        else
            $display("gamepad_hid_report_decoder test failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #1000000;
        $display("Timed out with %0d decoded reports outstanding.", expected_reports.size());
        $display("gamepad_hid_report_decoder test failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/ghrd_pkg.sv
rtl/ghrd_ctrl.sv
rtl/ghrd_datapath.sv
rtl/gamepad_hid_report_decoder.sv
rtl/ghrd_checker.sv
tb/gamepad_hid_report_decoder_tb.sv
